// File: sv/sliding_window_median_defines.svh
// Assertion macros used by the sliding window median RTL.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SWM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/swm_pkg.sv
// Shared constants, types and helpers of the sliding window median filter.
package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int CFG_W        = 7;
  localparam int IDX_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);

  typedef logic [SAMPLE_WIDTH-1:0] swm_sample_t;
  typedef logic [IDX_W-1:0]        swm_idx_t;
  typedef logic [CNT_W-1:0]        swm_cnt_t;

  // Per-beat broadcast from control to every cell
  typedef struct packed {
    logic        en;
    logic        full;
    swm_idx_t    age_lim;
    swm_sample_t sample;
  } swm_bcast_t;

  // What a cell shows its neighbours
  typedef struct packed {
    swm_sample_t val;
    swm_idx_t    age;
    logic        le;
    logic        rem;
  } swm_cell_out_t;

  function automatic swm_cnt_t eff_k(input logic [CFG_W-1:0] v);
    swm_cnt_t k;
    if (v == '0) begin
      k = CNT_W'(1);
    end else if (32'(v) > 32'(MAX_WINDOW)) begin
      k = CNT_W'(MAX_WINDOW);
    end else begin
      k = CNT_W'(v);
    end
    return k;
  endfunction

endpackage

// File: sv/sliding_window_median.sv
// Sliding window lower median filter: control, handshakes and result register.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_sample, in_start_req
//   out_     output     out_valid/out_ready  out_median
//   cfg_     input      cfg_we               cfg_window_size
//
// One beat per clock when the result side keeps up. A beat updates every cell
// of the sorted chain; the median is then taken from the chain into the output
// register once the output is free.
// Synchronous active-low reset empties the window and sets the size to 1.
// A stalled output holds one pending result in the chain; input stalls then.
module sliding_window_median import swm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                    in_start_req,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_median,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_window_size
);

`include "sliding_window_median_defines.svh"

  swm_cnt_t    k_r, fill_r, fill_nxt, n0;
  logic        pend_r, out_valid_r;
  swm_sample_t out_median_r;
  logic        accept, full, emit, out_free;
  swm_bcast_t  bc;
  swm_idx_t    mid;
  swm_sample_t median;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !pend_r || out_free;
  assign accept   = in_valid && in_ready;

  assign n0       = (in_start_req || (fill_r > k_r)) ? '0 : fill_r;
  assign full     = (n0 == k_r);
  assign fill_nxt = full ? k_r : n0 + CNT_W'(1);
  assign emit     = (fill_nxt == k_r);
  assign mid      = IDX_W'((k_r - CNT_W'(1)) >> 1);

  assign bc.en      = accept;
  assign bc.full    = full;
  assign bc.age_lim = IDX_W'(k_r - CNT_W'(1));
  assign bc.sample  = in_sample;

  swm_chain u_chain (
    .clk    (clk),
    .bc     (bc),
    .n0     (n0),
    .mid    (mid),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= CNT_W'(1);
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_r    <= eff_k(cfg_window_size);
        fill_r <= '0;
      end else if (accept) begin
        fill_r <= fill_nxt;
      end
      if (pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        pend_r <= emit;
      end else if (out_free) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_median_r <= median;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = $signed(out_median_r);

  `SWM_ASSERT_ALWAYS(a_fill_in_range, fill_r <= k_r, "fill count above window size")
  `SWM_ASSERT_ALWAYS(a_k_in_range, (k_r != '0) && (k_r <= CNT_W'(MAX_WINDOW)), "bad window size")
  `SWM_ASSERT_NEXT(a_emit_pending, accept && emit, pend_r, "result lost after beat")
  `SWM_ASSERT_NEXT(a_pending_held, pend_r && !out_free && !cfg_we, pend_r && $stable(fill_r),
                   "pending result dropped while output stalled")

endmodule

// File: sv/swm_cell.sv
// One cell of the sorted chain: holds one window entry and its age.
module swm_cell import swm_pkg::*; (
  input  logic          clk,
  input  swm_bcast_t    bc,
  input  logic          occ,
  input  logic          ra_lo,
  input  logic          ra,
  input  swm_cell_out_t lo,
  input  swm_cell_out_t hi,
  output swm_cell_out_t co
);

  swm_sample_t val_r, val_nxt;
  swm_idx_t    age_r, age_nxt;
  logic        le;
  swm_sample_t ap_val, lp_val;
  swm_idx_t    ap_age, lp_age;
  logic        ap_le, lp_le;

  assign le = occ && ($signed(val_r) <= $signed(bc.sample));

  // entry view after removal of the oldest
  assign ap_val = ra ? hi.val : val_r;
  assign ap_age = ra ? hi.age : age_r;
  assign ap_le  = ra ? hi.le  : le;
  assign lp_val = ra_lo ? val_r : lo.val;
  assign lp_age = ra_lo ? age_r : lo.age;
  assign lp_le  = ra_lo ? le    : lo.le;

  always_comb begin
    if (ap_le) begin
      val_nxt = ap_val;
      age_nxt = ap_age + IDX_W'(1);
    end else if (lp_le) begin
      val_nxt = bc.sample;
      age_nxt = '0;
    end else begin
      val_nxt = lp_val;
      age_nxt = lp_age + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (bc.en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign co.val = val_r;
  assign co.age = age_r;
  assign co.le  = le;
  assign co.rem = bc.full && occ && (age_r == bc.age_lim);

endmodule

// File: sv/swm_chain.sv
// Row of sorted cells with removal prefix and median tap select.
module swm_chain import swm_pkg::*; (
  input  logic        clk,
  input  swm_bcast_t  bc,
  input  swm_cnt_t    n0,
  input  swm_idx_t    mid,
  output swm_sample_t median
);

  swm_cell_out_t          co [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  rem;
  logic [MAX_WINDOW-1:0]  ra;
  swm_cell_out_t          lo_tie;

  assign lo_tie = '{val: '0, age: '0, le: 1'b1, rem: 1'b0};

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rem[i] = co[i].rem;
    end
  end

  // ra[i]: removed entry sits at or below cell i
  always_comb begin
    ra[0] = rem[0];
    for (int i = 1; i < MAX_WINDOW; i++) begin
      ra[i] = ra[i-1] | rem[i];
    end
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    swm_cell_out_t lo_c, hi_c;
    logic          ra_lo_c;
    logic          occ_c;

    assign occ_c = (CNT_W'(g) < n0);

    if (g == 0) begin : g_lo_end
      assign lo_c    = lo_tie;
      assign ra_lo_c = 1'b0;
    end else begin : g_lo_mid
      assign lo_c    = co[g-1];
      assign ra_lo_c = ra[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_hi_end
      assign hi_c = '{val: co[g].val, age: co[g].age, le: 1'b0, rem: 1'b0};
    end else begin : g_hi_mid
      assign hi_c = co[g+1];
    end

    swm_cell u_cell (
      .clk   (clk),
      .bc    (bc),
      .occ   (occ_c),
      .ra_lo (ra_lo_c),
      .ra    (ra[g]),
      .lo    (lo_c),
      .hi    (hi_c),
      .co    (co[g])
    );
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (IDX_W'(i) == mid) begin
        median = median | co[i].val;
      end
    end
  end

endmodule
